FILE: src/abca_pkg.sv
// Shared types, constants and codes for the atlas block chunk allocator.
// Used by the allocator top level and its divider; no dependencies.
package abca_pkg;

	// field widths
	localparam int PIDX_W    = 3;
	localparam int POOLS_MAX = 8;
	localparam int PIU_W     = 4;
	localparam int SLOT_W    = 5;
	localparam int FIRST_W   = 24;
	localparam int COUNT_W   = 25;
	localparam int DIM_W     = 15;
	localparam int DIVR_W    = 11;
	localparam int SUM_W     = 26;
	localparam int STAT_W    = 3;
	localparam int OP_W      = 2;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_W     = 60;
	localparam int HCNT_W    = 3;
	localparam int HINT_N    = 4;

	// parameter defaults
	localparam int POOL_BLOCKS_DEF    = 65536;
	localparam int POOL_LIMIT_DEF     = 8;
	localparam int FREE_SLOTS_DEF     = 16;
	localparam int DEFAULT_HEIGHT_DEF = 64;

	// largest block total of one pool
	localparam logic [SUM_W-1:0] BLOCK_CAP = SUM_W'(1 << 24);

	// opcodes
	localparam logic [OP_W-1:0] OP_ALLOC   = 2'd0;
	localparam logic [OP_W-1:0] OP_RELEASE = 2'd1;
	localparam logic [OP_W-1:0] OP_CLEAR   = 2'd2;

	// result status codes
	localparam logic [STAT_W-1:0] ST_ALLOCATED = 3'd0;
	localparam logic [STAT_W-1:0] ST_REFUSED   = 3'd1;
	localparam logic [STAT_W-1:0] ST_RELEASED  = 3'd2;
	localparam logic [STAT_W-1:0] ST_IGNORED   = 3'd3;
	localparam logic [STAT_W-1:0] ST_CLEARED   = 3'd4;
	localparam logic [STAT_W-1:0] ST_LIST_FULL = 3'd5;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_EXACT_SIZE   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_WIDTH    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_HEIGHT   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_WIDTH    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_HEIGHT   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_HINT_COUNT   = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_HINT_WIDTHS  = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_HINT_HEIGHTS = 3'd7;

	typedef struct packed {
		logic [OP_W-1:0]    opcode;
		logic [COUNT_W-1:0] block_count;
		logic [PIDX_W-1:0]  chunk_pool;
		logic [FIRST_W-1:0] chunk_first;
		logic [COUNT_W-1:0] chunk_count;
	} in_item_t;

	typedef struct packed {
		logic [STAT_W-1:0]  status;
		logic [PIDX_W-1:0]  out_pool;
		logic [FIRST_W-1:0] out_first;
		logic [COUNT_W-1:0] out_count;
		logic               pool_resized;
		logic [DIM_W-1:0]   pool_width;
		logic [DIM_W-1:0]   pool_height;
	} out_item_t;

	// one free-list entry
	typedef struct packed {
		logic [FIRST_W-1:0] first;
		logic [COUNT_W-1:0] count;
	} run_t;

endpackage

FILE: src/atlas_block_chunk_allocator.sv
// Atlas block chunk allocator: top level with the request sequencer and pool table.
// Depends on abca_pkg, abca_ram (free-list memory) and abca_div (growth limit).
//
// Usage:
//  - in channel (in_valid/in_ready/in_data) takes one request item: allocate,
//    release or clear. in_ready is high only while the sequencer is idle, so
//    one item is worked on at a time. Opcode 3 is dropped with no result.
//  - out channel (out_valid/out_ready/out_data) gives one result item per
//    request through an output register; the next request is taken while a
//    result still waits there.
//  - cfg channel (cfg_valid/cfg_ready/cfg_index/cfg_data) writes a setting; it
//    is always ready and is meant to be used while the block is idle.
//  - Sequencing: a clear, or an allocate refused for its block count, goes
//    straight to the result. A search visits each free-list entry with one
//    memory read and one compare; removing or inserting an entry shifts the
//    entries one by one, a read and a write each. Growing a pool also runs
//    the divider, one quotient bit per cycle.
//  - Free lists live in one RAM of POOL_LIMIT*FREE_SLOTS entries; pool sizes
//    live in flops. Reset empties all pools and loads the default settings.
//  - While the output register is full and out_ready is low, a finished result waits in the sequencer.
module atlas_block_chunk_allocator import abca_pkg::*; #(
	parameter int POOL_BLOCKS    = POOL_BLOCKS_DEF,
	parameter int POOL_LIMIT     = POOL_LIMIT_DEF,
	parameter int FREE_SLOTS     = FREE_SLOTS_DEF,
	parameter int DEFAULT_HEIGHT = DEFAULT_HEIGHT_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  in_item_t             in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output out_item_t            out_data,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	localparam int RAM_DEPTH = POOL_LIMIT * FREE_SLOTS;
	localparam int RA_W      = $clog2(RAM_DEPTH);
	localparam int QW        = $clog2(POOL_BLOCKS + 1);
	localparam int RUN_W     = FIRST_W + COUNT_W;

	// sequencer states
	localparam logic [4:0] S_IDLE    = 5'd0;
	localparam logic [4:0] S_DONE    = 5'd1;
	localparam logic [4:0] S_R_CHK   = 5'd2;
	localparam logic [4:0] S_R_LOOP  = 5'd3;
	localparam logic [4:0] S_R_CMP   = 5'd4;
	localparam logic [4:0] S_RM_RD   = 5'd5;
	localparam logic [4:0] S_RM_WR   = 5'd6;
	localparam logic [4:0] S_IN_RD   = 5'd7;
	localparam logic [4:0] S_IN_WR   = 5'd8;
	localparam logic [4:0] S_A_SCAN  = 5'd9;
	localparam logic [4:0] S_A_CHK   = 5'd10;
	localparam logic [4:0] S_A_NOFIT = 5'd11;
	localparam logic [4:0] S_A_TOP   = 5'd12;
	localparam logic [4:0] S_A_TOPC  = 5'd13;
	localparam logic [4:0] S_A_TOPD  = 5'd14;
	localparam logic [4:0] S_A_EXT   = 5'd15;
	localparam logic [4:0] S_N_NEW   = 5'd16;
	localparam logic [4:0] S_N_MUL   = 5'd17;
	localparam logic [4:0] S_N_TOT   = 5'd18;
	localparam logic [4:0] S_N_FIN   = 5'd19;
	localparam logic [4:0] S_G_START = 5'd20;
	localparam logic [4:0] S_G_OLD   = 5'd21;
	localparam logic [4:0] S_G_WAIT  = 5'd22;
	localparam logic [4:0] S_G_T1    = 5'd23;
	localparam logic [4:0] S_G_T1C   = 5'd24;
	localparam logic [4:0] S_G_T2    = 5'd25;
	localparam logic [4:0] S_G_T2C   = 5'd26;

	// settings
	logic                 exact_q;
	logic [DIM_W-1:0]     maxw_q, maxh_q, minw_q, minh_q;
	logic [HCNT_W-1:0]    hcnt_q;
	logic [CFG_W-1:0]     hintw_q, hinth_q;

	// pool table
	logic [PIU_W-1:0]     piu_q;
	logic [DIM_W-1:0]     pw_q [POOLS_MAX];
	logic [DIM_W-1:0]     ph_q [POOLS_MAX];
	logic [COUNT_W-1:0]   pt_q [POOLS_MAX];
	logic [SLOT_W-1:0]    fe_q [POOLS_MAX];

	// sequencer registers
	logic [4:0]           state_q, ret_q;
	logic [PIU_W-1:0]     cp_q;
	logic [SLOT_W-1:0]    k_q, i_q, ins_k_q, top_k_q;
	run_t                 ins_run_q;
	logic [COUNT_W-1:0]   bc_q, rc_q, top_c_q, need_q;
	logic [FIRST_W-1:0]   rf_q, top_f_q;
	logic                 top_valid_q, gret_ext_q;
	logic [DIM_W-1:0]     gw_q, gh_q, x_q, y_q;
	logic [SUM_W-1:0]     old_q, tot_q, gained_q;
	out_item_t            res_q;
	logic                 out_valid_q;
	out_item_t            out_data_q;

	// memory and divider ports
	logic                 ram_we;
	logic [RA_W-1:0]      ram_waddr, ram_raddr;
	run_t                 ram_wdata, rd;
	logic [RUN_W-1:0]     ram_rdata;
	logic                 div_start, div_busy;
	logic [QW-1:0]        div_q;

	// combinational helpers
	logic [PIDX_W-1:0]    pidx;
	logic [SLOT_W-1:0]    n_cur;
	logic [COUNT_W-1:0]   tot_cur;
	logic [SUM_W-1:0]     rd_end, rel_end, mul_res;
	logic                 list_full;
	logic [HCNT_W-1:0]    hc, hc_min1;
	logic [1:0]           hint_idx;
	logic [DIM_W-1:0]     base_w, base_h, cw0, ch0, cw1, ch1;
	logic [COUNT_W-1:0]   top_free;
	logic [SUM_W-1:0]     left_ext, fb1, fb2;
	logic [FIRST_W-1:0]   first_ext;
	logic [DIM_W-1:0]     lim0, lim1, lim2, ny;
	logic                 dnz, g1_fit, g1_ok, g2_ok;
	logic [4:0]           grow_fail_next;

	function automatic logic [RA_W-1:0] slot(input logic [PIDX_W-1:0] p,
			input logic [SLOT_W-1:0] k);
		return RA_W'(int'(p) * FREE_SLOTS + int'(k));
	endfunction

	abca_ram #(
		.WIDTH (RUN_W),
		.DEPTH (RAM_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	abca_div #(
		.DIVIDEND (POOL_BLOCKS)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.divisor  (gw_q[DIM_W-1:4]),
		.busy     (div_busy),
		.quotient (div_q)
	);

	// shared block-total multiplier; operands come from registers
	assign mul_res = SUM_W'(x_q[DIM_W-1:2]) * SUM_W'(y_q[DIM_W-1:2]);

	// current pool and entry views
	assign rd        = run_t'(ram_rdata);
	assign pidx      = cp_q[PIDX_W-1:0];
	assign n_cur     = fe_q[pidx];
	assign tot_cur   = pt_q[pidx];
	assign rd_end    = SUM_W'(rd.first) + SUM_W'(rd.count);
	assign rel_end   = SUM_W'(rf_q) + SUM_W'(rc_q);
	assign list_full = n_cur >= SLOT_W'(FREE_SLOTS);

	// hint selection and clamping for a new pool
	assign hc       = (hcnt_q > HCNT_W'(HINT_N)) ? HCNT_W'(HINT_N) : hcnt_q;
	assign hc_min1  = (hc == '0) ? HCNT_W'(1) : hc;
	assign hint_idx = (piu_q < PIU_W'(hc)) ? piu_q[1:0] : 2'(hc - HCNT_W'(1));
	always_comb begin
		if (hc == '0) begin
			base_w = maxw_q;
			base_h = exact_q ? maxh_q : DIM_W'(DEFAULT_HEIGHT);
		end else begin
			base_w = hintw_q[DIM_W*int'(hint_idx) +: DIM_W];
			base_h = hinth_q[DIM_W*int'(hint_idx) +: DIM_W];
		end
	end
	assign cw0 = (base_w > maxw_q) ? maxw_q : base_w;
	assign ch0 = (base_h > maxh_q) ? maxh_q : base_h;
	assign cw1 = (cw0 < minw_q) ? minw_q : cw0;
	assign ch1 = (ch0 < minh_q) ? minh_q : ch0;

	// extension of the last pool
	assign top_free  = top_valid_q ? top_c_q : '0;
	assign left_ext  = gained_q + SUM_W'(top_free) - SUM_W'(bc_q);
	assign first_ext = top_valid_q ? top_f_q : tot_cur[FIRST_W-1:0];

	// growth limit and the two growth attempts
	assign dnz  = gw_q[DIM_W-1:4] != '0;
	assign lim0 = maxh_q;
	assign lim1 = (dnz && (32'(div_q) < 32'(lim0))) ? DIM_W'(div_q) : lim0;
	assign lim2 = (gw_q < lim1) ? gw_q : lim1;
	assign ny   = (gh_q < lim2) ? lim2 : gh_q;
	assign fb1    = tot_q - old_q;
	assign fb2    = (tot_q < old_q) ? '0 : tot_q - old_q;
	assign g1_fit = fb1 >= SUM_W'(need_q);
	assign g1_ok  = g1_fit && (tot_q <= BLOCK_CAP);
	assign g2_ok  = (fb2 >= SUM_W'(need_q)) && (tot_q <= BLOCK_CAP);
	assign grow_fail_next = gret_ext_q ? S_N_NEW : S_N_MUL;

	assign div_start = (state_q == S_G_START) && dnz;

	// free-list memory access per state
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = '0;
		ram_wdata = '0;
		ram_raddr = '0;
		case (state_q)
			S_R_LOOP, S_A_SCAN: begin
				ram_raddr = slot(pidx, k_q);
			end
			S_A_TOP: begin
				ram_raddr = slot(pidx, k_q - SLOT_W'(1));
			end
			S_RM_RD: begin
				ram_raddr = slot(pidx, i_q + SLOT_W'(1));
			end
			S_RM_WR: begin
				ram_we    = 1'b1;
				ram_waddr = slot(pidx, i_q);
				ram_wdata = rd;
			end
			S_IN_RD: begin
				ram_raddr = slot(pidx, i_q - SLOT_W'(1));
				if (!(i_q > ins_k_q)) begin
					ram_we    = 1'b1;
					ram_waddr = slot(pidx, ins_k_q);
					ram_wdata = ins_run_q;
				end
			end
			S_IN_WR: begin
				ram_we    = 1'b1;
				ram_waddr = slot(pidx, i_q);
				ram_wdata = rd;
			end
			S_A_CHK: begin
				// shrink the run from its low end
				if (rd.count > bc_q) begin
					ram_we          = 1'b1;
					ram_waddr       = slot(pidx, k_q);
					ram_wdata.first = FIRST_W'(SUM_W'(rd.first) + SUM_W'(bc_q));
					ram_wdata.count = rd.count - bc_q;
				end
			end
			S_A_EXT: begin
				if (top_valid_q && (left_ext != '0)) begin
					ram_we          = 1'b1;
					ram_waddr       = slot(pidx, top_k_q);
					ram_wdata.first = FIRST_W'(SUM_W'(first_ext) + SUM_W'(bc_q));
					ram_wdata.count = COUNT_W'(left_ext);
				end
			end
			S_N_FIN: begin
				if ((tot_q >= SUM_W'(bc_q)) && (tot_q <= BLOCK_CAP)
						&& (SUM_W'(bc_q) < tot_q)) begin
					ram_we          = 1'b1;
					ram_waddr       = slot(pidx, '0);
					ram_wdata.first = FIRST_W'(bc_q);
					ram_wdata.count = COUNT_W'(tot_q - SUM_W'(bc_q));
				end
			end
			default: begin
			end
		endcase
	end

	// settings registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exact_q <= 1'b0;
			maxw_q  <= DIM_W'(16384);
			maxh_q  <= DIM_W'(16384);
			minw_q  <= DIM_W'(4);
			minh_q  <= DIM_W'(4);
			hcnt_q  <= '0;
			hintw_q <= '0;
			hinth_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_EXACT_SIZE:   exact_q <= cfg_data[0];
				CFG_MAX_WIDTH:    maxw_q  <= cfg_data[DIM_W-1:0];
				CFG_MAX_HEIGHT:   maxh_q  <= cfg_data[DIM_W-1:0];
				CFG_MIN_WIDTH:    minw_q  <= cfg_data[DIM_W-1:0];
				CFG_MIN_HEIGHT:   minh_q  <= cfg_data[DIM_W-1:0];
				CFG_HINT_COUNT:   hcnt_q  <= cfg_data[HCNT_W-1:0];
				CFG_HINT_WIDTHS:  hintw_q <= cfg_data;
				CFG_HINT_HEIGHTS: hinth_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// sequencer and pool table
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			piu_q       <= '0;
			out_valid_q <= 1'b0;
			for (int p = 0; p < POOLS_MAX; p++) begin
				pw_q[p] <= '0;
				ph_q[p] <= '0;
				pt_q[p] <= '0;
				fe_q[p] <= '0;
			end
		end else begin
			// output register
			if ((state_q == S_DONE) && (!out_valid_q || out_ready)) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						res_q <= '0;
						bc_q  <= in_data.block_count;
						cp_q  <= PIU_W'(in_data.chunk_pool);
						rf_q  <= in_data.chunk_first;
						rc_q  <= in_data.chunk_count;
						k_q   <= '0;
						case (in_data.opcode)
							OP_ALLOC: begin
								if ((in_data.block_count == '0)
										|| (in_data.block_count > COUNT_W'(POOL_BLOCKS))) begin
									res_q.status <= ST_REFUSED;
									state_q      <= S_DONE;
								end else begin
									cp_q    <= '0;
									state_q <= S_A_SCAN;
								end
							end
							OP_RELEASE: begin
								if ((in_data.chunk_count == '0)
										|| (PIU_W'(in_data.chunk_pool) >= piu_q)) begin
									res_q.status <= ST_IGNORED;
									state_q      <= S_DONE;
								end else begin
									state_q <= S_R_CHK;
								end
							end
							OP_CLEAR: begin
								piu_q <= '0;
								for (int p = 0; p < POOLS_MAX; p++) begin
									pw_q[p] <= '0;
									ph_q[p] <= '0;
									pt_q[p] <= '0;
									fe_q[p] <= '0;
								end
								res_q.status <= ST_CLEARED;
								state_q      <= S_DONE;
							end
							default: begin
							end
						endcase
					end
				end

				S_DONE: begin
					if (!out_valid_q || out_ready) begin
						out_data_q <= res_q;
						state_q    <= S_IDLE;
					end
				end

				// release: bounds, then merge with neighbors until none touches
				S_R_CHK: begin
					if ((rf_q >= FIRST_W'(tot_cur)) && (tot_cur <= COUNT_W'({FIRST_W{1'b1}}))
							|| (rel_end > SUM_W'(tot_cur))) begin
						res_q.status <= ST_IGNORED;
						state_q      <= S_DONE;
					end else begin
						k_q     <= '0;
						state_q <= S_R_LOOP;
					end
				end
				S_R_LOOP: begin
					if (k_q == n_cur) begin
						if (list_full) begin
							res_q.status <= ST_LIST_FULL;
							state_q      <= S_DONE;
						end else begin
							res_q.status    <= ST_RELEASED;
							ins_k_q         <= n_cur;
							i_q             <= n_cur;
							ins_run_q.first <= rf_q;
							ins_run_q.count <= rc_q;
							ret_q           <= S_DONE;
							state_q         <= S_IN_RD;
						end
					end else begin
						state_q <= S_R_CMP;
					end
				end
				S_R_CMP: begin
					if (rd_end == SUM_W'(rf_q)) begin
						rf_q    <= rd.first;
						rc_q    <= rc_q + rd.count;
						i_q     <= k_q;
						k_q     <= '0;
						ret_q   <= S_R_LOOP;
						state_q <= S_RM_RD;
					end else if (rel_end == SUM_W'(rd.first)) begin
						rc_q    <= rc_q + rd.count;
						i_q     <= k_q;
						k_q     <= '0;
						ret_q   <= S_R_LOOP;
						state_q <= S_RM_RD;
					end else if ((k_q + SLOT_W'(1) == n_cur) && (rd_end == SUM_W'(tot_cur))) begin
						// goes just before the top run
						if (list_full) begin
							res_q.status <= ST_LIST_FULL;
							state_q      <= S_DONE;
						end else begin
							res_q.status    <= ST_RELEASED;
							ins_k_q         <= k_q;
							i_q             <= n_cur;
							ins_run_q.first <= rf_q;
							ins_run_q.count <= rc_q;
							ret_q           <= S_DONE;
							state_q         <= S_IN_RD;
						end
					end else begin
						k_q     <= k_q + SLOT_W'(1);
						state_q <= S_R_LOOP;
					end
				end

				// remove entry i: shift later entries down one by one
				S_RM_RD: begin
					if (({1'b0, i_q} + 6'd1) < {1'b0, n_cur}) begin
						state_q <= S_RM_WR;
					end else begin
						fe_q[pidx] <= n_cur - SLOT_W'(1);
						state_q    <= ret_q;
					end
				end
				S_RM_WR: begin
					i_q     <= i_q + SLOT_W'(1);
					state_q <= S_RM_RD;
				end

				// insert at ins_k: shift entries up from the end, then write
				S_IN_RD: begin
					if (i_q > ins_k_q) begin
						state_q <= S_IN_WR;
					end else begin
						fe_q[pidx] <= n_cur + SLOT_W'(1);
						state_q    <= ret_q;
					end
				end
				S_IN_WR: begin
					i_q     <= i_q - SLOT_W'(1);
					state_q <= S_IN_RD;
				end

				// allocate: first fit over pools, then entries
				S_A_SCAN: begin
					if (cp_q == piu_q) begin
						state_q <= S_A_NOFIT;
					end else if (k_q == n_cur) begin
						cp_q <= cp_q + PIU_W'(1);
						k_q  <= '0;
					end else begin
						state_q <= S_A_CHK;
					end
				end
				S_A_CHK: begin
					if (rd.count >= bc_q) begin
						res_q.status       <= ST_ALLOCATED;
						res_q.out_pool     <= pidx;
						res_q.out_first    <= rd.first;
						res_q.out_count    <= bc_q;
						res_q.pool_resized <= 1'b0;
						res_q.pool_width   <= pw_q[pidx];
						res_q.pool_height  <= ph_q[pidx];
						if (rd.count == bc_q) begin
							i_q     <= k_q;
							ret_q   <= S_DONE;
							state_q <= S_RM_RD;
						end else begin
							state_q <= S_DONE;
						end
					end else begin
						k_q     <= k_q + SLOT_W'(1);
						state_q <= S_A_SCAN;
					end
				end
				S_A_NOFIT: begin
					if (exact_q && (piu_q >= PIU_W'(hc_min1))) begin
						res_q.status <= ST_REFUSED;
						state_q      <= S_DONE;
					end else if (!exact_q && (piu_q != '0)) begin
						cp_q        <= piu_q - PIU_W'(1);
						k_q         <= fe_q[PIDX_W'(piu_q - PIU_W'(1))];
						top_valid_q <= 1'b0;
						state_q     <= S_A_TOP;
					end else begin
						state_q <= S_N_NEW;
					end
				end

				// find the run that ends at the block total, from the back
				S_A_TOP: begin
					if (k_q == '0) begin
						state_q <= S_A_TOPD;
					end else begin
						state_q <= S_A_TOPC;
					end
				end
				S_A_TOPC: begin
					if (rd_end == SUM_W'(tot_cur)) begin
						top_valid_q <= 1'b1;
						top_k_q     <= k_q - SLOT_W'(1);
						top_f_q     <= rd.first;
						top_c_q     <= rd.count;
						state_q     <= S_A_TOPD;
					end else begin
						k_q     <= k_q - SLOT_W'(1);
						state_q <= S_A_TOP;
					end
				end
				S_A_TOPD: begin
					if (top_free < bc_q) begin
						need_q     <= bc_q - top_free;
						gw_q       <= pw_q[pidx];
						gh_q       <= ph_q[pidx];
						gret_ext_q <= 1'b1;
						state_q    <= S_G_START;
					end else begin
						state_q <= S_N_NEW;
					end
				end
				S_A_EXT: begin
					if (!top_valid_q && (left_ext != '0) && list_full) begin
						res_q.status <= ST_LIST_FULL;
						state_q      <= S_DONE;
					end else begin
						ph_q[pidx]         <= gh_q;
						pt_q[pidx]         <= COUNT_W'(tot_q);
						res_q.status       <= ST_ALLOCATED;
						res_q.out_pool     <= pidx;
						res_q.out_first    <= first_ext;
						res_q.out_count    <= bc_q;
						res_q.pool_resized <= 1'b1;
						res_q.pool_width   <= pw_q[pidx];
						res_q.pool_height  <= gh_q;
						ret_q              <= S_DONE;
						if (!top_valid_q) begin
							if (left_ext != '0) begin
								ins_k_q         <= n_cur;
								i_q             <= n_cur;
								ins_run_q.first <= FIRST_W'(SUM_W'(first_ext) + SUM_W'(bc_q));
								ins_run_q.count <= COUNT_W'(left_ext);
								state_q         <= S_IN_RD;
							end else begin
								state_q <= S_DONE;
							end
						end else if (left_ext != '0) begin
							state_q <= S_DONE;
						end else begin
							i_q     <= top_k_q;
							state_q <= S_RM_RD;
						end
					end
				end

				// open a new pool
				S_N_NEW: begin
					if (piu_q >= PIU_W'(POOL_LIMIT)) begin
						res_q.status <= ST_REFUSED;
						state_q      <= S_DONE;
					end else begin
						cp_q <= piu_q;
						if (exact_q) begin
							gw_q    <= base_w;
							gh_q    <= base_h;
							state_q <= S_N_MUL;
						end else begin
							gw_q       <= {cw1[DIM_W-1:2], 2'b00};
							gh_q       <= {ch1[DIM_W-1:2], 2'b00};
							need_q     <= bc_q;
							gret_ext_q <= 1'b0;
							state_q    <= S_G_START;
						end
					end
				end
				S_N_MUL: begin
					x_q     <= gw_q;
					y_q     <= gh_q;
					state_q <= S_N_TOT;
				end
				S_N_TOT: begin
					tot_q   <= mul_res;
					state_q <= S_N_FIN;
				end
				S_N_FIN: begin
					if ((tot_q < SUM_W'(bc_q)) || (tot_q > BLOCK_CAP)) begin
						res_q.status <= ST_REFUSED;
					end else begin
						piu_q              <= piu_q + PIU_W'(1);
						pw_q[pidx]         <= gw_q;
						ph_q[pidx]         <= gh_q;
						pt_q[pidx]         <= COUNT_W'(tot_q);
						fe_q[pidx]         <= (SUM_W'(bc_q) < tot_q) ? SLOT_W'(1) : '0;
						res_q.status       <= ST_ALLOCATED;
						res_q.out_pool     <= pidx;
						res_q.out_first    <= '0;
						res_q.out_count    <= bc_q;
						res_q.pool_resized <= 1'b1;
						res_q.pool_width   <= gw_q;
						res_q.pool_height  <= gh_q;
					end
					state_q <= S_DONE;
				end

				// height growth of pool (gw_q, gh_q) by at least need_q blocks
				S_G_START: begin
					x_q     <= gw_q;
					y_q     <= gh_q;
					state_q <= S_G_OLD;
				end
				S_G_OLD: begin
					old_q   <= mul_res;
					state_q <= S_G_WAIT;
				end
				S_G_WAIT: begin
					if (!div_busy) begin
						y_q     <= ny;
						state_q <= S_G_T1;
					end
				end
				S_G_T1: begin
					tot_q   <= mul_res;
					state_q <= S_G_T1C;
				end
				S_G_T1C: begin
					if (g1_fit) begin
						if (g1_ok) begin
							gh_q     <= y_q;
							gained_q <= fb1;
							state_q  <= gret_ext_q ? S_A_EXT : S_N_MUL;
						end else begin
							state_q <= grow_fail_next;
						end
					end else begin
						y_q     <= maxh_q;
						state_q <= S_G_T2;
					end
				end
				S_G_T2: begin
					tot_q   <= mul_res;
					state_q <= S_G_T2C;
				end
				S_G_T2C: begin
					if (g2_ok) begin
						gh_q     <= maxh_q;
						gained_q <= fb2;
						state_q  <= gret_ext_q ? S_A_EXT : S_N_MUL;
					end else begin
						state_q <= grow_fail_next;
					end
				end

				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign in_ready  = state_q == S_IDLE;
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

FILE: src/abca_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
module abca_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

FILE: src/abca_div.sv
// Restoring divider: a fixed dividend over an 11-bit divisor, one bit per cycle.
// Depends on abca_pkg.
module abca_div import abca_pkg::*; #(
	parameter int DIVIDEND = POOL_BLOCKS_DEF,
	localparam int QW = $clog2(DIVIDEND + 1)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [DIVR_W-1:0] divisor,
	output logic              busy,
	output logic [QW-1:0]     quotient
);

	localparam int CW = $clog2(QW + 1);

	logic [DIVR_W-1:0] d_q;
	logic [DIVR_W-1:0] rem_q;
	logic [QW-1:0]     quo_q;
	logic [CW-1:0]     cnt_q;
	logic              busy_q;
	logic [DIVR_W:0]   trial;
	logic              take;

	// shift in the next dividend bit and try a subtract
	assign trial = {rem_q, quo_q[QW-1]};
	assign take  = trial >= {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CW'(QW);
		end else if (busy_q) begin
			cnt_q <= cnt_q - CW'(1);
			if (cnt_q == CW'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			d_q   <= divisor;
			rem_q <= '0;
			quo_q <= QW'(DIVIDEND);
		end else if (busy_q) begin
			if (take) begin
				rem_q <= DIVR_W'(trial - {1'b0, d_q});
			end else begin
				rem_q <= trial[DIVR_W-1:0];
			end
			quo_q <= {quo_q[QW-2:0], take};
		end
	end

	assign busy     = busy_q;
	assign quotient = quo_q;

endmodule
